// ===== design/irpwd_pkg.sv =====
// Shared types and constants for the infrared pulse-width frame decoder.
// Holds event codes, register indexes, reset values and the bundles that
// pass between the top level and the decode core.
`timescale 1ns / 1ps

package irpwd_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PULSE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_START_WIDTH  = 3'd0,
    REG_ZERO_WIDTH   = 3'd1,
    REG_ONE_WIDTH    = 3'd2,
    REG_REPEAT_WIDTH = 3'd3,
    REG_TOLERANCE    = 3'd4,
    REG_TIMEOUT      = 3'd5,
    REG_DEVICE_ID    = 3'd6
  } reg_idx_t;

  localparam logic [15:0] START_WIDTH_RST  = 16'd4500;
  localparam logic [15:0] ZERO_WIDTH_RST   = 16'd560;
  localparam logic [15:0] ONE_WIDTH_RST    = 16'd1680;
  localparam logic [15:0] REPEAT_WIDTH_RST = 16'd2500;
  localparam logic [11:0] TOLERANCE_RST    = 12'd240;
  localparam logic [7:0]  TIMEOUT_RST      = 8'd14;
  localparam logic [7:0]  DEVICE_ID_RST    = 8'd0;

  typedef struct packed {
    logic [15:0] start_width;
    logic [15:0] zero_width;
    logic [15:0] one_width;
    logic [15:0] repeat_width;
    logic [11:0] tolerance;
    logic [7:0]  timeout_ticks;
    logic [7:0]  device_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] address;
    logic       frame_ended;
    logic [7:0] repeat_seen;
  } result_t;

endpackage

// ===== design/irpwd_core.sv =====
// Decode core: frame state machine, bit word, tick and repeat counters.
// Applies one event per enabled cycle; the read result is combinational.
// Depends on irpwd_pkg.
`timescale 1ns / 1ps

module irpwd_core (
  input  logic                clk,
  input  logic                rst,
  input  irpwd_pkg::cfg_t     cfg,
  input  logic                ev_valid,
  input  logic [1:0]          ev_op,
  input  logic [15:0]         ev_width,
  output irpwd_pkg::result_t  res
);

  typedef enum logic [3:0] {
    PH_WAIT   = 4'b0001,
    PH_START  = 4'b0010,
    PH_REPEAT = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] bit_word, bit_word_next;
  logic [8:0]  tick_count, tick_count_next;
  logic [7:0]  repeat_count, repeat_count_next;
  logic [7:0]  last_command, last_command_next;
  logic [7:0]  last_address, last_address_next;

  logic        win_start, win_zero, win_one, win_repeat;
  logic [8:0]  tick_inc;
  logic [31:0] word_after_zero;
  logic        frame_ended;

  // Strict signed window: a negative lower bound never rejects.
  function automatic logic in_window(input logic [15:0] w, input logic [15:0] nom,
                                     input logic [11:0] tol);
    logic signed [17:0] lo;
    logic signed [17:0] hi;
    logic signed [17:0] ws;
    lo = $signed({2'b00, nom}) - $signed({6'b000000, tol});
    hi = $signed({2'b00, nom}) + $signed({6'b000000, tol});
    ws = $signed({2'b00, w});
    return (ws > lo) && (ws < hi);
  endfunction

  assign win_start  = in_window(ev_width, cfg.start_width, cfg.tolerance);
  assign win_zero   = in_window(ev_width, cfg.zero_width, cfg.tolerance);
  assign win_one    = in_window(ev_width, cfg.one_width, cfg.tolerance);
  assign win_repeat = in_window(ev_width, cfg.repeat_width, cfg.tolerance);
  assign tick_inc   = tick_count + 9'd1;
  assign word_after_zero = win_zero ? {bit_word[30:0], 1'b0} : bit_word;

  always_comb begin
    phase_next        = phase;
    bit_word_next     = bit_word;
    tick_count_next   = tick_count;
    repeat_count_next = repeat_count;
    last_command_next = last_command;
    last_address_next = last_address;
    frame_ended       = 1'b0;
    unique case (irpwd_pkg::op_t'(ev_op))
      irpwd_pkg::OP_TICK: begin
        if (phase == PH_START || phase == PH_REPEAT) begin
          if (tick_inc > {1'b0, cfg.timeout_ticks}) begin
            phase_next      = PH_STOP;
            tick_count_next = '0;
          end else begin
            tick_count_next = tick_inc;
          end
        end else if (phase == PH_STOP) begin
          tick_count_next = '0;
        end
      end
      irpwd_pkg::OP_PULSE: begin
        unique case (phase)
          PH_WAIT: begin
            if (win_start) phase_next = PH_START;
          end
          PH_START: begin
            // zero and one windows may overlap: shift twice then
            bit_word_next = win_one ? {word_after_zero[30:0], 1'b1} : word_after_zero;
            if (win_repeat) begin
              phase_next        = PH_REPEAT;
              repeat_count_next = repeat_count + 8'd1;
            end
          end
          PH_REPEAT: begin
            if (win_repeat) repeat_count_next = repeat_count + 8'd1;
          end
          PH_STOP: begin
          end
          default: begin
          end
        endcase
      end
      irpwd_pkg::OP_READ: begin
        if (phase == PH_STOP) begin
          if (bit_word[31:24] == ~bit_word[23:16] && bit_word[31:24] == cfg.device_id) begin
            last_address_next = bit_word[31:24];
            if (bit_word[15:8] == ~bit_word[7:0]) last_command_next = bit_word[15:8];
          end
          phase_next        = PH_WAIT;
          bit_word_next     = '0;
          repeat_count_next = '0;
          frame_ended       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.command     = last_command_next;
  assign res.address     = last_address_next;
  assign res.frame_ended = frame_ended;
  assign res.repeat_seen = repeat_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      bit_word     <= '0;
      tick_count   <= '0;
      repeat_count <= '0;
      last_command <= '0;
      last_address <= '0;
    end else if (ev_valid) begin
      phase        <= phase_next;
      bit_word     <= bit_word_next;
      tick_count   <= tick_count_next;
      repeat_count <= repeat_count_next;
      last_command <= last_command_next;
      last_address <= last_address_next;
    end
  end

endmodule

// ===== design/ir_pulse_width_frame_decoder.sv =====
// Top level of the infrared pulse-width frame decoder: configuration
// registers, input register, result register and handshakes.
// Depends on irpwd_pkg and irpwd_core.
//
// Usage:
//   Requests enter on in_valid/in_ready with op (0 overflow tick,
//   1 measured high pulse with pulse_width, 2 read, 3 ignored).
//   Only a read produces a result, on out_valid/out_ready with command,
//   address, frame_ended and repeat_seen.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 start, 1 zero, 2 one, 3 repeat width, 4 tolerance, 5 timeout,
//   6 device id) in the same cycle; write only while the block is idle.
//   Path: an accepted request waits in the input register, then is applied
//   to the state machine by the edge that also loads the result register,
//   which drives out_valid; a read can be held in the input register (see Stall).
//   Throughput: one request per cycle while no read is held; the window
//   compares and state update are combinational, between input and result register.
//   Stall: while the result register is full and out_ready is low, a read
//   waits in the input register and in_ready drops; ticks and pulses keep
//   flowing until a read reaches the input register.
//   Reset: configuration and core registers take their default values, the machine returns to
//   wait, counters and the bit word clear, and no result is pending.
`timescale 1ns / 1ps

module ir_pulse_width_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] pulse_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  command,
  output logic [7:0]  address,
  output logic        frame_ended,
  output logic [7:0]  repeat_seen
);

  irpwd_pkg::cfg_t    cfg;
  irpwd_pkg::result_t res;
  irpwd_pkg::result_t res_q;

  logic        stage_valid;
  logic [1:0]  stage_op;
  logic [15:0] stage_width;
  logic        is_read;
  logic        apply;

  assign is_read  = (stage_op == irpwd_pkg::OP_READ);
  // hold a read while the result register cannot take it
  assign apply    = stage_valid && (!is_read || !out_valid || out_ready);
  assign in_ready = !stage_valid || apply;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_width   <= irpwd_pkg::START_WIDTH_RST;
      cfg.zero_width    <= irpwd_pkg::ZERO_WIDTH_RST;
      cfg.one_width     <= irpwd_pkg::ONE_WIDTH_RST;
      cfg.repeat_width  <= irpwd_pkg::REPEAT_WIDTH_RST;
      cfg.tolerance     <= irpwd_pkg::TOLERANCE_RST;
      cfg.timeout_ticks <= irpwd_pkg::TIMEOUT_RST;
      cfg.device_id     <= irpwd_pkg::DEVICE_ID_RST;
    end else if (cfg_we) begin
      unique case (irpwd_pkg::reg_idx_t'(cfg_index))
        irpwd_pkg::REG_START_WIDTH:  cfg.start_width   <= cfg_data;
        irpwd_pkg::REG_ZERO_WIDTH:   cfg.zero_width    <= cfg_data;
        irpwd_pkg::REG_ONE_WIDTH:    cfg.one_width     <= cfg_data;
        irpwd_pkg::REG_REPEAT_WIDTH: cfg.repeat_width  <= cfg_data;
        irpwd_pkg::REG_TOLERANCE:    cfg.tolerance     <= cfg_data[11:0];
        irpwd_pkg::REG_TIMEOUT:      cfg.timeout_ticks <= cfg_data[7:0];
        irpwd_pkg::REG_DEVICE_ID:    cfg.device_id     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_op    <= op;
      stage_width <= pulse_width;
    end
  end

  irpwd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .ev_valid (apply),
    .ev_op    (stage_op),
    .ev_width (stage_width),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply && is_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply && is_read) begin
      res_q <= res;
    end
  end

  assign command     = res_q.command;
  assign address     = res_q.address;
  assign frame_ended = res_q.frame_ended;
  assign repeat_seen = res_q.repeat_seen;

endmodule
